/* rtl/core/b64sd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the character decode function for the Base64 stream decoder.
// No dependencies.
package b64sd_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [1:0] SLOT_THIRD = 2'd2;
    localparam logic [1:0] SLOT_LAST  = 2'd3;

    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  count;
        logic        last;
        logic        failed;
    } t_group_cmd;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet s;
        s.valid = 1'b1;
        s.value = 6'd0;
        priority if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
            s.value = 6'(ch - CHAR_UP_A);
        end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
            s.value = 6'(ch - CHAR_LO_A + 8'd26);
        end else if (ch >= CHAR_DIG_0 && ch <= CHAR_DIG_9) begin
            s.value = 6'(ch - CHAR_DIG_0 + 8'd52);
        end else if (ch == CHAR_PLUS) begin
            s.value = 6'd62;
        end else if (ch == CHAR_SLASH) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

/* rtl/core/b64sd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts characters, tracks group position and errors, and builds group commands.
// Depends on b64sd_pkg.
module b64sd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_symbol,
    input  logic                 i_final_symbol,
    input  logic                 i_fifo_full,
    output logic                 o_push,
    output b64sd_pkg::t_group_cmd o_push_cmd
);
    import b64sd_pkg::*;

    logic [1:0]  r_slot, n_slot;
    logic [17:0] r_partial, n_partial;
    logic        r_third_pad, n_third_pad;
    logic        r_err, n_err;

    t_sextet     w_sx;
    logic        w_accept;
    logic        w_is_pad;
    logic        w_bad;
    logic        w_err_now;
    logic [5:0]  w_val;
    logic        w_fail;
    logic        w_group_done;

    assign o_ready   = !i_fifo_full;
    assign w_accept  = i_valid && o_ready;
    assign w_sx      = sextet_of(i_symbol);
    assign w_is_pad  = (i_symbol == PAD_CHAR);
    assign w_bad     = w_is_pad ? (r_slot < SLOT_THIRD) : !w_sx.valid;
    assign w_err_now = r_err || w_bad;
    assign w_val     = (w_is_pad || !w_sx.valid) ? 6'd0 : w_sx.value;
    assign w_fail    = i_final_symbol && (w_err_now || (r_slot != SLOT_LAST));
    assign w_group_done = !w_err_now && (r_slot == SLOT_LAST);

    assign o_push = w_accept && (w_fail || w_group_done);

    always_comb begin
        o_push_cmd.word   = w_fail ? 24'd0 : {r_partial, w_val};
        o_push_cmd.last   = i_final_symbol;
        o_push_cmd.failed = w_fail;
        if (w_fail) begin
            o_push_cmd.count = 2'd1;
        end else if (i_final_symbol) begin
            o_push_cmd.count = 2'd3 - 2'(r_third_pad) - 2'(w_is_pad);
        end else begin
            o_push_cmd.count = 2'd3;
        end
    end

    always_comb begin
        n_slot      = r_slot;
        n_partial   = r_partial;
        n_third_pad = r_third_pad;
        n_err       = r_err;
        if (w_accept) begin
            priority if (w_fail) begin
                n_slot      = 2'd0;
                n_partial   = 18'd0;
                n_third_pad = 1'b0;
                n_err       = 1'b0;
            end else if (w_err_now) begin
                n_slot = r_slot + 2'd1;
                n_err  = 1'b1;
            end else if (r_slot != SLOT_LAST) begin
                if (r_slot == SLOT_THIRD) begin
                    n_third_pad = w_is_pad;
                end
                n_partial = {r_partial[11:0], w_val};
                n_slot    = r_slot + 2'd1;
            end else begin
                n_slot      = 2'd0;
                n_partial   = 18'd0;
                n_third_pad = 1'b0;
                n_err       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= 2'd0;
            r_partial   <= 18'd0;
            r_third_pad <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            r_slot      <= n_slot;
            r_partial   <= n_partial;
            r_third_pad <= n_third_pad;
            r_err       <= n_err;
        end
    end

endmodule

/* rtl/core/b64sd_fifo.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the byte emitter.
// Depends on b64sd_pkg.
module b64sd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64sd_pkg::t_group_cmd i_push_cmd,
    input  logic                 i_pop,
    output b64sd_pkg::t_group_cmd o_head_cmd,
    output logic                 o_full,
    output logic                 o_empty
);
    import b64sd_pkg::*;

    t_group_cmd           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full     = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && !o_empty;
    assign o_head_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CW'(w_do_push) - FIFO_CW'(w_do_pop);
        end
    end

endmodule

/* rtl/core/b64sd_back.sv */
`timescale 1ns / 1ps
// Back end: takes group commands and emits their bytes one per transaction through an output register.
// Depends on b64sd_pkg.
module b64sd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fifo_empty,
    input  b64sd_pkg::t_group_cmd i_head_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_data_byte,
    output logic                 o_end_of_data,
    output logic                 o_failed
);
    import b64sd_pkg::*;

    t_group_cmd  r_cmd;
    logic        r_busy, n_busy;
    logic [1:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_failed;

    logic        w_load_out;
    logic        w_emit;
    logic        w_idx_last;
    logic [7:0]  w_byte;

    assign w_load_out = !r_out_valid || i_ready;
    assign w_emit     = r_busy && w_load_out;
    assign w_idx_last = (r_idx == r_cmd.count - 2'd1);
    assign o_pop      = !i_fifo_empty && (!r_busy || (w_emit && w_idx_last));

    always_comb begin
        unique case (r_idx)
            2'd0:    w_byte = r_cmd.word[23:16];
            2'd1:    w_byte = r_cmd.word[15:8];
            default: w_byte = r_cmd.word[7:0];
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = w_emit;
        end
        if (w_emit) begin
            n_idx = r_idx + 2'd1;
            if (w_idx_last) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head_cmd;
        end
        if (w_emit) begin
            r_out_byte   <= w_byte;
            r_out_last   <= r_cmd.last && w_idx_last;
            r_out_failed <= r_cmd.failed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_data_byte   = r_out_byte;
    assign o_end_of_data = r_out_last;
    assign o_failed      = r_out_failed;

endmodule

/* rtl/core/base64_stream_decoder.sv */
`timescale 1ns / 1ps
// Top level of the Base64 stream decoder: front end, command queue and byte emitter.
// Depends on b64sd_pkg, b64sd_front, b64sd_fifo and b64sd_back.
//
// Channel   Handshake           Payload
// input     i_valid / o_ready   i_symbol[7:0], i_final_symbol
// output    o_valid / i_ready   o_data_byte[7:0], o_end_of_data, o_failed
//
// One character is taken per cycle while the four-entry command queue has room.
// A completed group leaves one, two or three bytes, one per cycle from the output register while i_ready is high.
// The first byte of a group passes through the queue, the command register and the output register.
// Reset is synchronous and active low; it clears group state, the queue and the output stage.
// A stalled output fills the queue, and then o_ready drops until an entry drains.
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_final_symbol,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_end_of_data,
    output logic       o_failed
);
    import b64sd_pkg::*;

    logic        w_push;
    t_group_cmd  w_push_cmd;
    logic        w_pop;
    t_group_cmd  w_head_cmd;
    logic        w_full;
    logic        w_empty;

    b64sd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_symbol       (i_symbol),
        .i_final_symbol (i_final_symbol),
        .i_fifo_full    (w_full),
        .o_push         (w_push),
        .o_push_cmd     (w_push_cmd)
    );

    b64sd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_head_cmd (w_head_cmd),
        .o_full     (w_full),
        .o_empty    (w_empty)
    );

    b64sd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_empty  (w_empty),
        .i_head_cmd    (w_head_cmd),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_byte   (o_data_byte),
        .o_end_of_data (o_end_of_data),
        .o_failed      (o_failed)
    );

`ifndef ASSERT_OFF
    a_final_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_final_symbol) |-> (w_push && w_push_cmd.last))
        else $error("final character did not produce a closing command");

    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_failed) |-> (o_end_of_data && (o_data_byte == 8'd0)))
        else $error("failed result is not a closing zero byte");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from an empty queue");
`endif

endmodule
